// ===== hw/rtl/sensor_frame_checksum_parser_top_defines.svh =====
// Assertion macros shared by the frame parser checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef SENSOR_FRAME_CHECKSUM_PARSER_TOP_DEFINES_SVH
`define SENSOR_FRAME_CHECKSUM_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while rstn is low.
`define SFCP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sfcp assertion failed");

// Next-cycle implication, disabled while rstn is low.
`define SFCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sfcp assertion failed");

`endif

// ===== hw/rtl/sfcp_pkg.sv =====
// Types and constants of the sensor frame checksum parser.
// No dependencies; imported by every module of the block but sfcp_checker.
`default_nettype none

package sfcp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 4;
    localparam int unsigned CONC_W = 16;

    localparam logic [POS_W-1:0] POS_HUNT   = 4'd0;
    localparam logic [POS_W-1:0] POS_FIRST  = 4'd1;
    localparam logic [POS_W-1:0] POS_DIGITS = 4'd3;
    localparam logic [POS_W-1:0] POS_HIGH   = 4'd4;
    localparam logic [POS_W-1:0] POS_LOW    = 4'd5;
    localparam logic [POS_W-1:0] POS_CHECK  = 4'd8;

    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'hFF;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_MISMATCH = 1'b1;

    typedef struct packed {
        logic [CONC_W-1:0] concentration;
        logic [BYTE_W-1:0] decimal_digits;
        logic              frame_status;
    } sfcp_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfcp_in_reg.sv =====
// Input register of the parser: holds one received byte until it is consumed.
// Depends on sfcp_pkg.
`default_nettype none

module sfcp_in_reg
    import sfcp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_byte,
    input  wire logic              downstream_ready,
    output logic                   byte_valid,
    output logic [BYTE_W-1:0]      byte_data
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;

    // A held byte leaves whenever the output side can take a result.
    assign s_tready   = !valid_reg || downstream_ready;
    assign byte_valid = valid_reg && downstream_ready;
    assign byte_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_byte;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sfcp_frame_parser.sv =====
// Frame tracker: byte position, running checksum and held reading fields.
// Depends on sfcp_pkg.
`default_nettype none

module sfcp_frame_parser
    import sfcp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [BYTE_W-1:0] start_byte,
    input  wire logic              byte_valid,
    input  wire logic [BYTE_W-1:0] byte_data,
    output logic                   res_valid,
    output sfcp_result_t           res
);

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] sum_next;
    logic [BYTE_W-1:0] digits_reg;
    logic [BYTE_W-1:0] high_reg;
    logic [BYTE_W-1:0] low_reg;
    logic              hunting;
    logic [BYTE_W-1:0] check_total;

    // Positions beyond the checksum byte behave as hunting.
    assign hunting     = (pos_reg == POS_HUNT) || (pos_reg > POS_CHECK);
    // The checksum matches when it is the negated sum, i.e. sum plus it wraps to zero.
    assign check_total = sum_reg + byte_data;

    assign res_valid            = byte_valid && !hunting && (pos_reg == POS_CHECK);
    assign res.concentration    = {high_reg, low_reg};
    assign res.decimal_digits   = digits_reg;
    assign res.frame_status     = (check_total == '0) ? STATUS_OK : STATUS_MISMATCH;

    always_comb begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (byte_valid) begin
            if (hunting) begin
                if (byte_data == start_byte) begin
                    pos_next = POS_FIRST;
                    sum_next = '0;
                end else begin
                    pos_next = POS_HUNT;
                end
            end else if (pos_reg == POS_CHECK) begin
                pos_next = POS_HUNT;
            end else begin
                pos_next = pos_reg + POS_FIRST;
                sum_next = check_total;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_HUNT;
            sum_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_valid) begin
            case (pos_reg)
                POS_DIGITS: digits_reg <= byte_data;
                POS_HIGH:   high_reg   <= byte_data;
                POS_LOW:    low_reg    <= byte_data;
                default:    ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sfcp_out_reg.sv =====
// Result register of the parser, holding one finished frame result.
// Depends on sfcp_pkg.
`default_nettype none

module sfcp_out_reg
    import sfcp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         load,
    input  wire sfcp_result_t load_res,
    output logic              can_accept,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output sfcp_result_t      m_res
);

    logic         valid_reg;
    logic         valid_next;
    sfcp_result_t res_reg;

    assign can_accept = !valid_reg || m_tready;
    assign m_tvalid   = valid_reg;
    assign m_res      = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (can_accept) begin
            valid_next = load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_accept && load) begin
            res_reg <= load_res;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sensor_frame_checksum_parser_top.sv =====
// Timing: a byte is registered in the input register at its transfer, and its
// result, if any, is registered in the result register when that byte leaves the input register.
// Throughput: one byte per cycle; a stalled result output holds back the input.
// Reset: aresetn is synchronous and active low; the parser hunts for a start
// byte and the start byte register returns to 0xFF.
// Top level of the sensor frame checksum parser; uses sfcp_pkg and its submodules.
`default_nettype none

module sensor_frame_checksum_parser_top
    import sfcp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Start byte register write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,
    // Received bytes.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Frame results.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [15:0] concentration, [23:16] decimal_digits
    output logic [0:0]       m_tuser    // [0] frame_status
);

    logic [BYTE_W-1:0] start_byte_reg;
    logic              can_accept;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              res_valid;
    sfcp_result_t      res;
    sfcp_result_t      m_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= START_BYTE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            start_byte_reg <= cfg_data;
        end
    end

    sfcp_in_reg u_in_reg (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_byte           (s_tdata),
        .downstream_ready (can_accept),
        .byte_valid       (byte_valid),
        .byte_data        (byte_data)
    );

    sfcp_frame_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_byte (start_byte_reg),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .res_valid  (res_valid),
        .res        (res)
    );

    sfcp_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (res_valid),
        .load_res   (res),
        .can_accept (can_accept),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_res      (m_res)
    );

    assign m_tdata = {m_res.decimal_digits, m_res.concentration};
    assign m_tuser = m_res.frame_status;

endmodule

`default_nettype wire

// ===== hw/rtl/sfcp_checker.sv =====
// Port-level checks of the sensor frame checksum parser, bound to its top level.
// Depends on sensor_frame_checksum_parser_top_defines.svh.
`default_nettype none
`include "sensor_frame_checksum_parser_top_defines.svh"

module sfcp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // A stalled result keeps its contents.
    `SFCP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Reset empties the result register.
    `SFCP_ASSERT_NEXT(a_reset_clears, aclk, 1'b1, !aresetn, !m_tvalid)

    // With the result register empty the input side never stalls.
    `SFCP_ASSERT_IMPL(a_no_idle_stall, aclk, aresetn, !m_tvalid, s_tready)

    // A new result follows an input transfer, registered in the input register and then in the result register.
    `SFCP_ASSERT_IMPL(a_result_source, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

endmodule

bind sensor_frame_checksum_parser_top sfcp_checker u_sfcp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
